/* rtl/core/iriu_pkg.sv */
package iriu_pkg;

	// Word memory and register file geometry.
	localparam int MEM_WORDS = 65536;
	localparam int MEM_AW    = $clog2(MEM_WORDS);
	localparam int REG_COUNT = 16;
	localparam int REG_AW    = $clog2(REG_COUNT);

	// Field length and relocation are given in blocks of 256 words.
	localparam int BLOCK_SHIFT = 8;
	localparam int BASE_W      = 8;
	localparam int LENGTH_W    = 13;
	localparam int LIMIT_W     = LENGTH_W + BLOCK_SHIFT;
	localparam int PHYS_W      = LIMIT_W + 1;

	// Result queue between the pipeline and the output channel.
	localparam int FIFO_AW    = 3;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	// Opcodes.
	localparam logic [3:0] OP_JMPZ    = 4'd0;
	localparam logic [3:0] OP_JMPP    = 4'd1;
	localparam logic [3:0] OP_SETK    = 4'd2;
	localparam logic [3:0] OP_LOADJK  = 4'd3;
	localparam logic [3:0] OP_STOREJK = 4'd4;
	localparam logic [3:0] OP_ADDJK   = 4'd5;
	localparam logic [3:0] OP_SUBK    = 4'd6;
	localparam logic [3:0] OP_NEGATE  = 4'd7;
	localparam logic [3:0] OP_ADDK    = 4'd8;
	localparam logic [3:0] OP_MUL     = 4'd9;
	localparam logic [3:0] OP_LOADK   = 4'd10;

	// Configuration register indexes.
	localparam logic REG_BASE   = 1'b0;
	localparam logic REG_LENGTH = 1'b1;

	typedef struct packed {
		logic        jump_taken;
		logic        bound_fault;
		logic        fault_flag;
		logic [63:0] written_value;
	} res_t;

endpackage

/* rtl/core/index_register_instruction_unit_core.sv */
// An accepted word passes the stage 1, 2 and 3 registers into the result queue, whose
// head is offered on rsp_valid. One word per cycle while req_stall is low; a word that
// reads the destination of the multiply just ahead of it is held, as the product is
// summed in the second stage. The eight-entry result queue holds the pipeline's output
// while rsp_stall is high. Reset clears all control state, the register file valid bits
// and the fault bit, then a clearing pass zeroes the word memory with req_stall high.
module index_register_instruction_unit_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [3:0]  req_type,
	input  logic [3:0]  reg_i,
	input  logic [3:0]  reg_j,
	input  logic [3:0]  reg_k,
	input  logic [3:0]  short_k,
	input  logic [19:0] long_k,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        jump_taken,
	output logic        bound_fault,
	output logic        fault_flag,
	output logic [63:0] written_value
);

	localparam int AW = iriu_pkg::REG_AW;

	// Configuration
	logic [iriu_pkg::BASE_W-1:0]   base_q;
	logic [iriu_pkg::LENGTH_W-1:0] length_q;

	// Memory clearing pass
	logic                        clearing_q;
	logic [iriu_pkg::MEM_AW-1:0] clr_addr_q;

	// Storage
	logic [63:0]                 mem_q [iriu_pkg::MEM_WORDS];
	logic [63:0]                 rf_j_q [iriu_pkg::REG_COUNT];
	logic [63:0]                 rf_k_q [iriu_pkg::REG_COUNT];
	logic [63:0]                 rf_i_q [iriu_pkg::REG_COUNT];
	logic [iriu_pkg::REG_COUNT-1:0] rf_valid_q;
	logic                        fault_q;

	// Stage 1
	logic          v_s1;
	logic [3:0]    op_s1;
	logic [AW-1:0] ri_s1, rj_s1, rk_s1;
	logic [3:0]    k4_s1;
	logic [19:0]   kl_s1;
	logic [63:0]   rdj_s1, rdk_s1, rdi_s1;
	logic          rvj_s1, rvk_s1, rvi_s1;

	// Stage 2
	logic          v_s2;
	logic          wr_en_s2;
	logic [AW-1:0] wa_s2;
	logic [63:0]   val_s2;
	logic          load_s2;
	logic          mul_s2;
	logic [63:0]   mp0_s2;
	logic [39:0]   mp1_s2;
	logic [63:0]   mem_rd_s2;
	logic          jump_s2, bad_s2, fault_s2;

	// Stage 3
	logic          v_s3;
	logic          wr_en_s3;
	logic [AW-1:0] wa_s3;
	logic [63:0]   val_s3;
	logic          jump_s3, bad_s3, fault_s3;

	// Last commit, kept for the register file read that shared its edge
	logic          wr_en_s4;
	logic [AW-1:0] wa_s4;
	logic [63:0]   val_s4;

	// Stage 1 logic
	logic [63:0]   xj, xk, xi, sxk, sum_jk, alu_val, offset;
	logic          in_field, in_mem, addr_ok, is_mem, bad, wr_en, jump;
	logic [AW-1:0] wa;
	logic [iriu_pkg::PHYS_W-1:0] phys;
	logic signed [72:0] p0_full;
	logic signed [71:0] p1_full;
	logic [63:0]   fwd2_val, mul_val;
	logic          mul_hazard, credit_full, accept, store_we;
	logic [iriu_pkg::FIFO_AW:0] fifo_count;
	logic [iriu_pkg::FIFO_AW:0] in_flight;
	iriu_pkg::res_t push_word, head;
	logic          pop;

	// Configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			length_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				iriu_pkg::REG_BASE:   base_q   <= pwdata[iriu_pkg::BASE_W-1:0];
				iriu_pkg::REG_LENGTH: length_q <= pwdata[iriu_pkg::LENGTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			iriu_pkg::REG_BASE:   prdata = 32'(base_q);
			iriu_pkg::REG_LENGTH: prdata = 32'(length_q);
			default:              prdata = '0;
		endcase
	end

	// Input handshake
	assign in_flight   = (iriu_pkg::FIFO_AW+1)'(v_s1) + (iriu_pkg::FIFO_AW+1)'(v_s2)
		+ (iriu_pkg::FIFO_AW+1)'(v_s3);
	assign credit_full = (fifo_count + in_flight) >= (iriu_pkg::FIFO_AW+1)'(iriu_pkg::FIFO_DEPTH);
	assign mul_hazard  = v_s1 && (op_s1 == iriu_pkg::OP_MUL)
		&& (reg_j == rj_s1 || reg_k == rj_s1 || reg_i == rj_s1);
	assign req_stall   = clearing_q || credit_full || mul_hazard;
	assign accept      = req_valid && !req_stall;

	// Register file: three read copies written together at commit
	always_ff @(posedge clk) begin
		if (v_s3 && wr_en_s3) begin
			rf_j_q[wa_s3] <= val_s3;
			rf_k_q[wa_s3] <= val_s3;
			rf_i_q[wa_s3] <= val_s3;
		end
		rdj_s1 <= rf_j_q[reg_j];
		rdk_s1 <= rf_k_q[reg_k];
		rdi_s1 <= rf_i_q[reg_i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_valid_q <= '0;
		end else if (v_s3 && wr_en_s3) begin
			rf_valid_q[wa_s3] <= 1'b1;
		end
	end

	// Stage 1 registers
	always_ff @(posedge clk) begin
		op_s1  <= req_type;
		ri_s1  <= reg_i;
		rj_s1  <= reg_j;
		rk_s1  <= reg_k;
		k4_s1  <= short_k;
		kl_s1  <= long_k;
		rvj_s1 <= rf_valid_q[reg_j];
		rvk_s1 <= rf_valid_q[reg_k];
		rvi_s1 <= rf_valid_q[reg_i];
	end

	// Youngest producer wins; a register never written reads as zero.
	function automatic logic [63:0] fwd(
		input logic [AW-1:0] idx,
		input logic [63:0]   rd,
		input logic          rv,
		input logic          e2,
		input logic [AW-1:0] a2,
		input logic [63:0]   d2,
		input logic          e3,
		input logic [AW-1:0] a3,
		input logic [63:0]   d3,
		input logic          e4,
		input logic [AW-1:0] a4,
		input logic [63:0]   d4
	);
		logic [63:0] r;
		if (e2 && a2 == idx) begin
			r = d2;
		end else if (e3 && a3 == idx) begin
			r = d3;
		end else if (e4 && a4 == idx) begin
			r = d4;
		end else if (rv) begin
			r = rd;
		end else begin
			r = '0;
		end
		return r;
	endfunction

	assign fwd2_val = load_s2 ? mem_rd_s2 : val_s2;

	always_comb begin
		xj = fwd(rj_s1, rdj_s1, rvj_s1, v_s2 && wr_en_s2 && !mul_s2, wa_s2, fwd2_val,
			v_s3 && wr_en_s3, wa_s3, val_s3, wr_en_s4, wa_s4, val_s4);
		xk = fwd(rk_s1, rdk_s1, rvk_s1, v_s2 && wr_en_s2 && !mul_s2, wa_s2, fwd2_val,
			v_s3 && wr_en_s3, wa_s3, val_s3, wr_en_s4, wa_s4, val_s4);
		xi = fwd(ri_s1, rdi_s1, rvi_s1, v_s2 && wr_en_s2 && !mul_s2, wa_s2, fwd2_val,
			v_s3 && wr_en_s3, wa_s3, val_s3, wr_en_s4, wa_s4, val_s4);
	end

	assign sxk    = {{60{k4_s1[3]}}, k4_s1};
	assign sum_jk = xj + xk;

	always_comb begin
		case (op_s1)
			iriu_pkg::OP_SETK:   alu_val = {60'd0, k4_s1};
			iriu_pkg::OP_ADDJK:  alu_val = sum_jk;
			iriu_pkg::OP_SUBK:   alu_val = xj - sxk;
			iriu_pkg::OP_NEGATE: alu_val = 64'd0 - xk;
			iriu_pkg::OP_ADDK:   alu_val = xj + sxk;
			default:             alu_val = '0;
		endcase
	end

	// Address check: inside the field, and inside the memory once relocated.
	assign offset   = (op_s1 == iriu_pkg::OP_LOADK) ? {44'd0, kl_s1} : sum_jk;
	assign in_field = (offset[63:iriu_pkg::LIMIT_W] == '0)
		&& (offset[iriu_pkg::LIMIT_W-1:0] < {length_q, {iriu_pkg::BLOCK_SHIFT{1'b0}}});
	assign phys     = iriu_pkg::PHYS_W'({base_q, {iriu_pkg::BLOCK_SHIFT{1'b0}}})
		+ iriu_pkg::PHYS_W'(offset[iriu_pkg::LIMIT_W-1:0]);
	assign in_mem   = phys < iriu_pkg::PHYS_W'(iriu_pkg::MEM_WORDS);
	assign addr_ok  = in_field && in_mem;

	always_comb begin
		case (op_s1) inside
			iriu_pkg::OP_LOADJK, iriu_pkg::OP_STOREJK, iriu_pkg::OP_LOADK: is_mem = 1'b1;
			default: is_mem = 1'b0;
		endcase
	end
	assign bad = is_mem && !addr_ok;

	always_comb begin
		case (op_s1) inside
			iriu_pkg::OP_SETK, iriu_pkg::OP_ADDJK, iriu_pkg::OP_SUBK,
			iriu_pkg::OP_NEGATE, iriu_pkg::OP_ADDK, iriu_pkg::OP_MUL: wr_en = 1'b1;
			iriu_pkg::OP_LOADJK, iriu_pkg::OP_LOADK: wr_en = addr_ok;
			default: wr_en = 1'b0;
		endcase
	end

	always_comb begin
		case (op_s1) inside
			iriu_pkg::OP_LOADJK, iriu_pkg::OP_ADDJK: wa = ri_s1;
			default: wa = rj_s1;
		endcase
	end

	always_comb begin
		case (op_s1)
			iriu_pkg::OP_JMPZ: jump = (xj == '0);
			iriu_pkg::OP_JMPP: jump = (xj != '0) && !xj[63];
			default:           jump = 1'b0;
		endcase
	end

	// The product of the low 48 bits is split on the second operand.
	assign p0_full = $signed(xj[47:0]) * $signed({1'b0, xk[23:0]});
	assign p1_full = $signed(xj[47:0]) * $signed(xk[47:24]);

	assign store_we = v_s1 && (op_s1 == iriu_pkg::OP_STOREJK) && addr_ok;

	// Word memory, with the clearing pass on its single write port
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem_q[clr_addr_q] <= '0;
		end else if (store_we) begin
			mem_q[phys[iriu_pkg::MEM_AW-1:0]] <= xi;
		end
		mem_rd_s2 <= mem_q[phys[iriu_pkg::MEM_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == iriu_pkg::MEM_AW'(iriu_pkg::MEM_WORDS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			wr_en_s4 <= 1'b0;
			fault_q  <= 1'b0;
		end else begin
			v_s1     <= accept;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			wr_en_s4 <= v_s3 && wr_en_s3;
			if (v_s1 && bad) begin
				fault_q <= 1'b1;
			end
		end
	end

	// Stage 2 and 3 payload
	always_ff @(posedge clk) begin
		wr_en_s2 <= wr_en;
		wa_s2    <= wa;
		val_s2   <= (op_s1 == iriu_pkg::OP_STOREJK) ? (addr_ok ? xi : '0) : alu_val;
		load_s2  <= ((op_s1 == iriu_pkg::OP_LOADJK) || (op_s1 == iriu_pkg::OP_LOADK)) && addr_ok;
		mul_s2   <= (op_s1 == iriu_pkg::OP_MUL);
		mp0_s2   <= p0_full[63:0];
		mp1_s2   <= p1_full[39:0];
		jump_s2  <= jump;
		bad_s2   <= bad;
		fault_s2 <= fault_q || bad;

		wr_en_s3 <= wr_en_s2;
		wa_s3    <= wa_s2;
		val_s3   <= mul_s2 ? mul_val : fwd2_val;
		jump_s3  <= jump_s2;
		bad_s3   <= bad_s2;
		fault_s3 <= fault_s2;

		wa_s4    <= wa_s3;
		val_s4   <= val_s3;
	end

	assign mul_val = mp0_s2 + {mp1_s2, 24'd0};

	// Result queue
	assign push_word.jump_taken    = jump_s3;
	assign push_word.bound_fault   = bad_s3;
	assign push_word.fault_flag    = fault_s3;
	assign push_word.written_value = val_s3;
	assign pop = rsp_valid && !rsp_stall;

	iriu_rsp_fifo u_rsp_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s3),
		.push_word (push_word),
		.pop       (pop),
		.head      (head),
		.nonempty  (rsp_valid),
		.count     (fifo_count)
	);

	assign jump_taken    = head.jump_taken;
	assign bound_fault   = head.bound_fault;
	assign fault_flag    = head.fault_flag;
	assign written_value = head.written_value;

	// A word in stage 1 never reads the destination of a multiply still being summed.
	a_no_mul_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && mul_s2) |-> !(rj_s1 == wa_s2 || rk_s1 == wa_s2 || ri_s1 == wa_s2))
		else $error("word in stage 1 reads an unfinished product");

	// Words in flight always have room in the result queue.
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_count + in_flight) <= (iriu_pkg::FIFO_AW+1)'(iriu_pkg::FIFO_DEPTH))
		else $error("result queue overcommitted");

	// The fault bit is sticky.
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q |=> fault_q)
		else $error("fault bit cleared");

	// A refused access writes no register.
	a_bad_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && bad_s3) |-> !wr_en_s3)
		else $error("refused access commits a register");

	// No word enters while the memory is still being cleared.
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |=> !v_s1)
		else $error("word accepted during clearing pass");

endmodule

/* rtl/core/iriu_rsp_fifo.sv */
module iriu_rsp_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  iriu_pkg::res_t          push_word,
	input  logic                    pop,
	output iriu_pkg::res_t          head,
	output logic                    nonempty,
	output logic [iriu_pkg::FIFO_AW:0] count
);

	iriu_pkg::res_t                 store_q [iriu_pkg::FIFO_DEPTH];
	logic [iriu_pkg::FIFO_AW-1:0]   wr_ptr_q;
	logic [iriu_pkg::FIFO_AW-1:0]   rd_ptr_q;
	logic [iriu_pkg::FIFO_AW:0]     count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (iriu_pkg::FIFO_AW+1)'(push) - (iriu_pkg::FIFO_AW+1)'(pop);
		end
	end

	assign head     = store_q[rd_ptr_q];
	assign nonempty = (count_q != '0);
	assign count    = count_q;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam logic [3:0] OP_SPARE_LO    = 4'd11;
	localparam logic [3:0] OP_SPARE_HI    = 4'd15;
	localparam int         WATCHDOG_LIMIT = 3 * iriu_pkg::MEM_WORDS;

	typedef struct packed {
		logic [3:0]  op;
		logic [3:0]  ri;
		logic [3:0]  rj;
		logic [3:0]  rk;
		logic [3:0]  sk;
		logic [19:0] lk;
	} insn_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [3:0]  req_type = '0;
	logic [3:0]  reg_i = '0;
	logic [3:0]  reg_j = '0;
	logic [3:0]  reg_k = '0;
	logic [3:0]  short_k = '0;
	logic [19:0] long_k = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic        jump_taken;
	logic        bound_fault;
	logic        fault_flag;
	logic [63:0] written_value;

	// Shadow of the block's state, kept in step with accepted words.
	bit [63:0]      xreg [iriu_pkg::REG_COUNT];
	bit [63:0]      mem_model [iriu_pkg::MEM_WORDS];
	bit             fault_sticky = 1'b0;
	bit [7:0]       base_cfg = '0;
	bit [12:0]      length_cfg = '0;

	iriu_pkg::res_t expected_results [$];
	int             fail_count = 0;
	int             issued = 0;
	bit             gaps_on = 1'b1;
	int             stall_left = 0;
	int             quiet_cycles = 0;

	index_register_instruction_unit_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_stall(req_stall),
		.req_type(req_type), .reg_i(reg_i), .reg_j(reg_j), .reg_k(reg_k),
		.short_k(short_k), .long_k(long_k),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.jump_taken(jump_taken), .bound_fault(bound_fault),
		.fault_flag(fault_flag), .written_value(written_value)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic iriu_pkg::res_t execute(input insn_t w);
		logic [63:0]    xj;
		logic [63:0]    xk;
		logic [63:0]    off;
		logic [63:0]    phys;
		iriu_pkg::res_t r;
		xj = xreg[w.rj];
		xk = xreg[w.rk];
		r = '0;
		case (w.op)
			iriu_pkg::OP_JMPZ: r.jump_taken = (xj == 64'd0);
			iriu_pkg::OP_JMPP: r.jump_taken = (xj != 64'd0) && !xj[63];
			iriu_pkg::OP_SETK: begin
				r.written_value = {60'd0, w.sk};
				xreg[w.rj] = r.written_value;
			end
			iriu_pkg::OP_LOADJK, iriu_pkg::OP_STOREJK, iriu_pkg::OP_LOADK: begin
				off = (w.op == iriu_pkg::OP_LOADK) ? {44'd0, w.lk} : xj + xk;
				phys = {48'd0, base_cfg, 8'd0} + off;
				// The field check comes first, so the relocated sum cannot wrap.
				if (off >= {43'd0, length_cfg, 8'd0} || phys >= iriu_pkg::MEM_WORDS) begin
					r.bound_fault = 1'b1;
				end else if (w.op == iriu_pkg::OP_STOREJK) begin
					r.written_value = xreg[w.ri];
					mem_model[phys[iriu_pkg::MEM_AW-1:0]] = r.written_value;
				end else begin
					r.written_value = mem_model[phys[iriu_pkg::MEM_AW-1:0]];
					if (w.op == iriu_pkg::OP_LOADJK) begin
						xreg[w.ri] = r.written_value;
					end else begin
						xreg[w.rj] = r.written_value;
					end
				end
			end
			iriu_pkg::OP_ADDJK: begin
				r.written_value = xj + xk;
				xreg[w.ri] = r.written_value;
			end
			iriu_pkg::OP_SUBK: begin
				r.written_value = xj - {{60{w.sk[3]}}, w.sk};
				xreg[w.rj] = r.written_value;
			end
			iriu_pkg::OP_NEGATE: begin
				r.written_value = 64'd0 - xk;
				xreg[w.rj] = r.written_value;
			end
			iriu_pkg::OP_ADDK: begin
				r.written_value = xj + {{60{w.sk[3]}}, w.sk};
				xreg[w.rj] = r.written_value;
			end
			iriu_pkg::OP_MUL: begin
				r.written_value = {{16{xj[47]}}, xj[47:0]} * {{16{xk[47]}}, xk[47:0]};
				xreg[w.rj] = r.written_value;
			end
			default: ;
		endcase
		if (r.bound_fault) begin
			fault_sticky = 1'b1;
		end
		r.fault_flag = fault_sticky;
		return r;
	endfunction

	function automatic insn_t word_of(input logic [3:0] op, input logic [3:0] ri,
			input logic [3:0] rj, input logic [3:0] rk, input logic [3:0] sk,
			input logic [19:0] lk);
		insn_t w;
		w.op = op;
		w.ri = ri;
		w.rj = rj;
		w.rk = rk;
		w.sk = sk;
		w.lk = lk;
		return w;
	endfunction

	function automatic insn_t random_word();
		return word_of(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
			4'($urandom), 20'($urandom));
	endfunction

	// Offers one word, holding it until it is taken, and records its result.
	task automatic issue(input insn_t w);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= w.op;
		reg_i     <= w.ri;
		reg_j     <= w.rj;
		reg_k     <= w.rk;
		short_k   <= w.sk;
		long_k    <= w.lk;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		expected_results.push_back(execute(w));
		issued++;
	endtask

	task automatic write_reg(input logic reg_index, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_index == iriu_pkg::REG_BASE) begin
			base_cfg = value[7:0];
		end else begin
			length_cfg = value[12:0];
		end
	endtask

	// Registers change only once the pipeline has emptied.
	task automatic set_field(input logic [7:0] b, input logic [12:0] len);
		req_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		write_reg(iriu_pkg::REG_BASE, {24'd0, b});
		write_reg(iriu_pkg::REG_LENGTH, {19'd0, len});
	endtask

	// Builds an offset in two registers, stores through it and often reads it back.
	task automatic memory_sequence();
		logic [3:0]  ra;
		logic [3:0]  rb;
		logic [63:0] where;
		insn_t       w;
		int          doublings;
		ra = 4'($urandom);
		rb = ra ^ 4'($urandom_range(1, 15));
		w = random_word();
		w.op = iriu_pkg::OP_SETK;
		w.rj = ra;
		issue(w);
		w = random_word();
		w.op = iriu_pkg::OP_SETK;
		w.rj = rb;
		issue(w);
		w = random_word();
		w.op = iriu_pkg::OP_MUL;
		w.rj = ra;
		w.rk = rb;
		issue(w);
		doublings = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
		repeat (doublings) begin
			w = random_word();
			w.op = iriu_pkg::OP_ADDJK;
			w.ri = ra;
			w.rj = ra;
			w.rk = ra;
			issue(w);
		end
		if ($urandom_range(0, 1) == 0) begin
			w = random_word();
			w.op = iriu_pkg::OP_ADDK;
			w.rj = ra;
			issue(w);
		end
		where = xreg[ra] + xreg[rb];
		w = random_word();
		w.op = iriu_pkg::OP_STOREJK;
		w.rj = ra;
		w.rk = rb;
		issue(w);
		case ($urandom_range(0, 2))
			0: begin
				w = random_word();
				w.op = iriu_pkg::OP_LOADJK;
				w.rj = rb;
				w.rk = ra;
				issue(w);
			end
			1: begin
				w = random_word();
				w.op = iriu_pkg::OP_LOADK;
				w.lk = where[19:0];
				issue(w);
			end
			default: ;
		endcase
	endtask

	task automatic run_phase(input logic [7:0] b, input logic [12:0] len, input int count);
		int target;
		set_field(b, len);
		target = issued + count;
		while (issued < target) begin
			if ($urandom_range(0, 9) < 6) begin
				memory_sequence();
			end else begin
				issue(random_word());
			end
		end
	endtask

	task automatic test_directed();
		set_field(8'd0, 13'd4096);
		issue(word_of(iriu_pkg::OP_SETK, 4'd0, 4'd1, 4'd0, 4'd15, 20'd0));
		issue(word_of(iriu_pkg::OP_SETK, 4'd0, 4'd2, 4'd0, 4'd0, 20'd0));
		issue(word_of(iriu_pkg::OP_JMPZ, 4'd0, 4'd2, 4'd0, 4'd0, 20'd0));
		issue(word_of(iriu_pkg::OP_JMPZ, 4'd0, 4'd1, 4'd0, 4'd0, 20'd0));
		issue(word_of(iriu_pkg::OP_JMPP, 4'd0, 4'd1, 4'd0, 4'd0, 20'd0));
		issue(word_of(iriu_pkg::OP_NEGATE, 4'd0, 4'd3, 4'd1, 4'd0, 20'd0));
		issue(word_of(iriu_pkg::OP_JMPP, 4'd0, 4'd3, 4'd0, 4'd0, 20'd0));
		issue(word_of(iriu_pkg::OP_JMPP, 4'd0, 4'd2, 4'd0, 4'd0, 20'd0));
		issue(word_of(iriu_pkg::OP_ADDK, 4'd0, 4'd4, 4'd0, 4'd8, 20'd0));
		issue(word_of(iriu_pkg::OP_SUBK, 4'd0, 4'd5, 4'd0, 4'd15, 20'd0));
		issue(word_of(iriu_pkg::OP_ADDK, 4'd0, 4'd6, 4'd0, 4'd7, 20'd0));
		issue(word_of(iriu_pkg::OP_MUL, 4'd0, 4'd3, 4'd3, 4'd0, 20'd0));
		issue(word_of(iriu_pkg::OP_ADDJK, 4'd7, 4'd3, 4'd4, 4'd0, 20'd0));
		issue(word_of(iriu_pkg::OP_STOREJK, 4'd4, 4'd7, 4'd5, 4'd0, 20'd0));
		issue(word_of(iriu_pkg::OP_LOADJK, 4'd8, 4'd7, 4'd5, 4'd0, 20'd0));
		issue(word_of(iriu_pkg::OP_LOADK, 4'd0, 4'd9, 4'd0, 4'd0, 20'd218));
		// Inside the field but past the end of memory.
		issue(word_of(iriu_pkg::OP_LOADK, 4'd0, 4'd10, 4'd0, 4'd0, 20'hFFFFF));
		issue(word_of(iriu_pkg::OP_NEGATE, 4'd0, 4'd11, 4'd5, 4'd0, 20'd0));
		// Minus one plus seven wraps round to a small, valid offset.
		issue(word_of(iriu_pkg::OP_STOREJK, 4'd6, 4'd11, 4'd6, 4'd0, 20'd0));
		issue(word_of(iriu_pkg::OP_LOADJK, 4'd12, 4'd11, 4'd11, 4'd0, 20'd0));
		issue(word_of(iriu_pkg::OP_SUBK, 4'd0, 4'd13, 4'd0, 4'd8, 20'd0));
		issue(word_of(iriu_pkg::OP_MUL, 4'd0, 4'd4, 4'd11, 4'd0, 20'd0));
		issue(word_of(OP_SPARE_LO, 4'd15, 4'd15, 4'd15, 4'd15, 20'hFFFFF));
		issue(word_of(OP_SPARE_HI, 4'd0, 4'd0, 4'd0, 4'd0, 20'd0));
	endtask

	task automatic test_field_settings();
		int bases   [8] = '{0, 0, 255, 255, 200, 3, 128, 1};
		int lengths [8] = '{1, 4096, 1, 0, 4096, 2, 128, 4095};
		foreach (bases[n]) begin
			run_phase(8'(bases[n]), 13'(lengths[n]), 115);
		end
	endtask

	// Dependent words back to back, with neither side holding back.
	task automatic test_back_to_back();
		gaps_on = 1'b0;
		run_phase(8'd0, 13'd256, 130);
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		iriu_pkg::res_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected");
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				compare_field("jump_taken", 64'(want.jump_taken), 64'(jump_taken));
				compare_field("bound_fault", 64'(want.bound_fault), 64'(bound_fault));
				compare_field("fault_flag", 64'(want.fault_flag), 64'(fault_flag));
				compare_field("written_value", want.written_value, written_value);
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else if (gaps_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 12);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// The limit covers the memory clearing pass after reset.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("index_register_instruction_unit_core test failed");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_field_settings();
		test_back_to_back();
		req_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (fail_count == 0) begin
			$display("index_register_instruction_unit_core test passed");
		end else begin
			$display("index_register_instruction_unit_core test failed");
		end
		$finish;
	end

endmodule
